### sv/two_level_page_walk_memory_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page walk memory unit
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_WALK_MEMORY_UNIT_MACROS_SVH
`define TWO_LEVEL_PAGE_WALK_MEMORY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define PWM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("forbidden");
`else
`define PWM_ASSERT(lbl, clk, rst_n, prop)
`define PWM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/pwm_pkg.sv
// ----------------------------------------------------------------------------
// Page walk memory package
// Shared constants and types.
// ----------------------------------------------------------------------------
package pwm_pkg;
  localparam int unsigned MemBytes = 65536;
  localparam int unsigned WordAw = $clog2(MemBytes / 4);
  localparam int unsigned WordDepth = MemBytes / 4;

  typedef enum logic [1:0] {
    OP_PHYS_RD = 2'd0,
    OP_PHYS_WR = 2'd1,
    OP_VIRT_RD = 2'd2,
    OP_VIRT_WR = 2'd3
  } op_e;

  typedef enum logic {
    CFG_PAGING = 1'b0,
    CFG_PDBASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DE_RD,
    ST_DE_CHK,
    ST_TE_RD,
    ST_TE_CHK,
    ST_TE_WB,
    ST_RANGE,
    ST_D0_RD,
    ST_D0_WR,
    ST_D1_RD,
    ST_D1_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        we;
    logic [WordAw-1:0] addr;
    logic [31:0] wdata;
    logic [3:0]  be;
  } mem_req_t;
endpackage

### sv/two_level_page_walk_memory_unit.sv
// ----------------------------------------------------------------------------
// Two-level page walk memory unit
// Byte memory behind an i386-style page walker, one item at a time.
// ----------------------------------------------------------------------------
// A zero-length item goes straight to its result. A physical access reads its
// word and, for a write, writes it; one that crosses a word boundary does the
// same for the next word. A virtual access first walks the tables on the
// single memory port, reading each entry and writing it back (the directory
// entry only if its accessed bit was clear); one that crosses a page makes two
// walks and two data parts. A result waiting on the output holds ST_DONE.
module two_level_page_walk_memory_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // address, length, write_data
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // read_data
  output logic [1:0]  m_axis_tuser,  // page_fault, out_of_range
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  import pwm_pkg::*;
  `include "two_level_page_walk_memory_unit_macros.svh"

  logic        paging_q;
  logic [19:0] pdbase_q;
  mem_req_t    req;
  logic [31:0] rdata;
  logic [33:0] res;
  logic        busy;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q <= 1'b0;
      pdbase_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PAGING) paging_q <= cfg_data_i[0];
      else pdbase_q <= cfg_data_i;
    end
  end

  pwm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .address_i(s_axis_tdata[31:0]),
    .length_i(s_axis_tdata[34:32]), .write_data_i(s_axis_tdata[66:35]),
    .paging_i(paging_q), .pdbase_i(pdbase_q),
    .mem_req_o(req), .mem_rdata_i(rdata),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res), .busy_o(busy)
  );

  pwm_ram #(.Width(32), .Depth(WordDepth)) u_ram (
    .clk_i, .we_i(req.we), .addr_i(req.addr), .wdata_i(req.wdata),
    .be_i(req.be), .rdata_o(rdata)
  );

  assign m_axis_tdata = res[31:0];
  assign m_axis_tuser = res[33:32];

  `PWM_ASSERT(a_no_accept_busy, clk_i, rst_ni, busy |-> !s_axis_tready)
  `PWM_ASSERT_NEVER(a_pf_oor, clk_i, rst_ni, m_axis_tvalid && res[32] && res[33])
  `PWM_ASSERT(a_err_zero, clk_i, rst_ni, (m_axis_tvalid && |m_axis_tuser) |-> m_axis_tdata == '0)
endmodule

### sv/pwm_ram.sv
// ----------------------------------------------------------------------------
// Generic single port RAM
// Byte-enable write, registered read.
// ----------------------------------------------------------------------------
module pwm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [Width/8-1:0]       be_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < Width / 8; b++) begin
        if (be_i[b]) mem[addr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
      end
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### sv/pwm_ctrl.sv
// ----------------------------------------------------------------------------
// Page walk memory controller
// Sequences walks, entry write-backs and data accesses on one memory port.
// ----------------------------------------------------------------------------
module pwm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [31:0]         address_i,
  input  logic [2:0]          length_i,
  input  logic [31:0]         write_data_i,
  input  logic                paging_i,
  input  logic [19:0]         pdbase_i,
  output pwm_pkg::mem_req_t   mem_req_o,
  input  logic [31:0]         mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [33:0]         res_o,
  output logic                busy_o
);
  import pwm_pkg::*;

  state_e      state_q, state_d;
  logic        wr_q, wr_d, split_q, split_d, part_q, part_d;
  logic [31:0] va_q, va_d, wdat_q, wdat_d, rd_q, rd_d;
  logic [2:0]  len_q, len_d, len1_q, len1_d;
  logic [31:0] pa0_q, pa0_d, pa1_q, pa1_d, ea_q, ea_d, ent_q, ent_d;
  logic        pf_q, pf_d, oor_q, oor_d;
  logic        hi_q, hi_d;
  logic [31:0] lo_q, lo_d;
  logic        ov_q, ov_d;
  logic [33:0] res_q, res_d;

  logic [31:0] wva, dbase, pa, ln32, shift_wd;
  logic [2:0]  plen;
  logic [1:0]  boff;
  logic [12:0] offsum;
  logic [33:0] lo_span;
  logic [63:0] wide_rd, wide_wd;
  logic [7:0]  be8;
  logic [WordAw-1:0] word_addr;
  logic        pa_ok, fin;

  assign wva = part_q ? (va_q + {29'd0, len1_q}) : va_q;
  assign pa = part_q ? pa1_q : pa0_q;
  assign plen = part_q ? (len_q - len1_q) : len1_q;
  assign boff = pa[1:0];
  assign word_addr = pa[WordAw+1:2] + {{(WordAw-1){1'b0}}, hi_q};
  assign lo_span = {2'b0, pa} + {31'd0, plen};
  assign pa_ok = lo_span <= 34'(MemBytes);
  assign ln32 = {29'd0, len1_q};
  assign shift_wd = part_q ? (wdat_q >> (ln32 << 3)) : wdat_q;
  assign wide_wd = {32'd0, shift_wd} << ({3'd0, boff} << 3);
  assign be8 = ((8'd1 << plen) - 8'd1) << boff;
  assign wide_rd = hi_q ? {mem_rdata_i, lo_q} : {32'd0, mem_rdata_i};
  assign dbase = {pdbase_i, 12'd0} + {20'd0, wva[31:22], 2'b00};
  assign offsum = {1'b0, address_i[11:0]} + {10'd0, length_i > 3'd4 ? 3'd4 : length_i};
  assign fin = ov_q && !res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q <= wr_d; split_q <= split_d; part_q <= part_d; va_q <= va_d;
    wdat_q <= wdat_d; rd_q <= rd_d; len_q <= len_d; len1_q <= len1_d;
    pa0_q <= pa0_d; pa1_q <= pa1_d; ea_q <= ea_d; ent_q <= ent_d;
    pf_q <= pf_d; oor_q <= oor_d; hi_q <= hi_d; lo_q <= lo_d; res_q <= res_d;
  end

  always_comb begin
    logic [2:0] l;
    logic [31:0] lane;
    logic virt;
    state_d = state_q; wr_d = wr_q; split_d = split_q; part_d = part_q;
    va_d = va_q; wdat_d = wdat_q; rd_d = rd_q; len_d = len_q; len1_d = len1_q;
    pa0_d = pa0_q; pa1_d = pa1_q; ea_d = ea_q; ent_d = ent_q;
    pf_d = pf_q; oor_d = oor_q; hi_d = hi_q; lo_d = lo_q; res_d = res_q; ov_d = ov_q;
    mem_req_o = '0;
    in_ready_o = 1'b0;
    l = 3'd0;
    lane = '0;
    virt = 1'b0;
    if (ov_q && res_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          l = length_i > 3'd4 ? 3'd4 : length_i;
          wr_d = opcode_i[0];
          va_d = address_i; wdat_d = write_data_i; len_d = l; len1_d = l;
          rd_d = '0; pf_d = 1'b0; oor_d = 1'b0; part_d = 1'b0; split_d = 1'b0;
          hi_d = 1'b0;
          virt = opcode_i[1] && paging_i;
          pa0_d = address_i;
          if (l == 3'd0) state_d = ST_DONE;
          else if (virt) begin
            if (offsum > 13'd4096) begin
              split_d = 1'b1;
              len1_d = 3'(13'd4096 - {1'b0, address_i[11:0]});
            end
            state_d = ST_DE_RD;
          end else state_d = ST_D0_RD;
        end
      end
      ST_DE_RD: begin
        ea_d = dbase;
        if ({2'b0, dbase} + 34'd4 > 34'(MemBytes)) begin
          oor_d = 1'b1; state_d = ST_DONE;
        end else begin
          mem_req_o.addr = dbase[WordAw+1:2];
          state_d = ST_DE_CHK;
        end
      end
      ST_DE_CHK: begin
        if (!mem_rdata_i[0]) begin
          pf_d = 1'b1; state_d = ST_DONE;
        end else begin
          if (!mem_rdata_i[5]) begin
            mem_req_o.we = 1'b1; mem_req_o.addr = ea_q[WordAw+1:2];
            mem_req_o.wdata = mem_rdata_i | 32'h20; mem_req_o.be = 4'hf;
          end
          ea_d = {mem_rdata_i[31:12], 12'd0} + {20'd0, wva[21:12], 2'b00};
          state_d = ST_TE_RD;
        end
      end
      ST_TE_RD: begin
        if ({2'b0, ea_q} + 34'd4 > 34'(MemBytes)) begin
          oor_d = 1'b1; state_d = ST_DONE;
        end else begin
          mem_req_o.addr = ea_q[WordAw+1:2];
          state_d = ST_TE_CHK;
        end
      end
      ST_TE_CHK: begin
        ent_d = mem_rdata_i | 32'h20 | (wr_q ? 32'h40 : 32'h0);
        if (!mem_rdata_i[0]) begin
          pf_d = 1'b1; state_d = ST_DONE;
        end else state_d = ST_TE_WB;
      end
      ST_TE_WB: begin
        mem_req_o.we = 1'b1; mem_req_o.addr = ea_q[WordAw+1:2];
        mem_req_o.wdata = ent_q; mem_req_o.be = 4'hf;
        if (part_q) pa1_d = {ent_q[31:12], wva[11:0]};
        else pa0_d = {ent_q[31:12], wva[11:0]};
        if (split_q && !part_q) begin
          part_d = 1'b1; state_d = ST_DE_RD;
        end else begin
          part_d = 1'b0; state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        state_d = ST_D0_RD;
      end
      ST_D0_RD, ST_D1_RD: begin
        if (!pa_ok) begin
          oor_d = 1'b1; rd_d = '0; state_d = ST_DONE;
        end else begin
          mem_req_o.addr = word_addr;
          state_d = (state_q == ST_D0_RD) ? ST_D0_WR : ST_D1_WR;
        end
        if (state_q == ST_D0_RD && split_q && pa_ok) begin
          if ({2'b0, pa1_q} + {31'd0, len_q - len1_q} > 34'(MemBytes)) begin
            oor_d = 1'b1; state_d = ST_DONE;
          end
        end
      end
      ST_D0_WR, ST_D1_WR: begin
        if (wr_q) begin
          mem_req_o.we = 1'b1; mem_req_o.addr = word_addr;
          mem_req_o.wdata = hi_q ? wide_wd[63:32] : wide_wd[31:0];
          mem_req_o.be = hi_q ? be8[7:4] : be8[3:0];
        end
        if (!hi_q && be8[7:4] != 4'd0) begin
          lo_d = mem_rdata_i; hi_d = 1'b1;
          state_d = (state_q == ST_D0_WR) ? ST_D0_RD : ST_D1_RD;
        end else begin
          hi_d = 1'b0;
          lane = wide_rd[({3'd0, boff} << 3) +: 32];
          lane = lane & ~(32'hffffffff << ({3'd0, plen} << 3));
          if (!wr_q) rd_d = part_q ? (rd_q | (lane << (ln32 << 3))) : lane;
          if (state_q == ST_D0_WR && split_q) begin
            part_d = 1'b1; state_d = ST_D1_RD;
          end else state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!fin) begin
          res_d = {oor_q, pf_q, (wr_q || pf_q || oor_q) ? 32'd0 : rd_q};
          ov_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_valid_o = ov_q;
  assign res_o = res_q;
  assign busy_o = state_q != ST_IDLE;
endmodule

### verif/two_level_page_walk_memory_unit_tb.sv
// ----------------------------------------------------------------------------
// Two-level page walk memory unit testbench
// Fills small data windows through physical writes and builds a page directory
// with page tables. It then runs physical and virtual reads and writes:
// directed corners first, then random items with random gaps on both streams
// and one long output stall. An in-bench predictor keeps a copy of memory and
// of both registers, and every result is checked field by field.
// ----------------------------------------------------------------------------
module two_level_page_walk_memory_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwm_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 20;
  localparam logic [31:0] PdAddr = 32'h1000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        page_fault;
    logic        out_of_range;
  } mem_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [19:0] cfg_data_i = '0;

  logic [7:0]  shadow_mem [MemBytes];
  logic        paging_on = 1'b0;
  logic [19:0] pd_frame = '0;
  mem_result_t pending_results [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned ranges_seen = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  two_level_page_walk_memory_unit dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk_i) begin
    mem_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result read_data=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.read_data) begin
          $error("read_data expected %h actual %h", want.read_data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.page_fault) begin
          $error("page_fault expected %b actual %b", want.page_fault, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.out_of_range) begin
          $error("out_of_range expected %b actual %b", want.out_of_range, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  function automatic bit fits(logic [31:0] a, int unsigned n);
    logic [31:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = a + i;
      if (b >= MemBytes) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] load_bytes(logic [31:0] a, int unsigned n);
    logic [31:0] v = '0;
    logic [31:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = a + i;
      v |= 32'(shadow_mem[b[15:0]]) << (8 * i);
    end
    return v;
  endfunction

  function automatic void store_bytes(logic [31:0] a, int unsigned n, logic [31:0] v);
    logic [31:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = a + i;
      shadow_mem[b[15:0]] = v[8*i +: 8];
    end
  endfunction

  // 0 ok, 1 not present, 2 out of range
  function automatic int translate(logic [31:0] va, bit wr, output logic [31:0] pa);
    logic [31:0] de_addr, de, te_addr, te;
    pa = '0;
    de_addr = {pd_frame, 12'h0} + {20'h0, va[31:22], 2'b0};
    if (!fits(de_addr, 4)) return 2;
    de = load_bytes(de_addr, 4);
    if (!de[0]) return 1;
    if (!de[5]) begin
      de[5] = 1'b1;
      store_bytes(de_addr, 4, de);
    end
    te_addr = {de[31:12], 12'h0} + {20'h0, va[21:12], 2'b0};
    if (!fits(te_addr, 4)) return 2;
    te = load_bytes(te_addr, 4);
    if (!te[0]) return 1;
    if (!te[5]) begin
      te[5] = 1'b1;
      store_bytes(te_addr, 4, te);
    end
    if (wr) begin
      te[6] = 1'b1;
      store_bytes(te_addr, 4, te);
    end
    pa = {te[31:12], va[11:0]};
    return 0;
  endfunction

  function automatic mem_result_t access_memory(op_e op, logic [31:0] addr, logic [2:0] len_f,
                                                logic [31:0] wdata);
    mem_result_t r = '0;
    int unsigned len, len1, len2 = 0;
    logic [31:0] pa1 = addr, pa2 = '0;
    bit wr = (op == OP_PHYS_WR) || (op == OP_VIRT_WR);
    int st = 0;
    len = (len_f > 4) ? 4 : len_f;
    if (len == 0) return r;
    len1 = len;
    if ((op == OP_VIRT_RD || op == OP_VIRT_WR) && paging_on) begin
      if (addr[11:0] + len > 4096) begin
        len1 = 4096 - addr[11:0];
        len2 = len - len1;
      end
      st = translate(addr, wr, pa1);
      if (st == 0 && len2 != 0) st = translate(addr + len1, wr, pa2);
      if (st == 1) begin
        r.page_fault = 1'b1;
        return r;
      end
      if (st == 2) begin
        r.out_of_range = 1'b1;
        return r;
      end
    end
    if (!fits(pa1, len1) || (len2 != 0 && !fits(pa2, len2))) begin
      r.out_of_range = 1'b1;
      return r;
    end
    if (wr) begin
      store_bytes(pa1, len1, wdata);
      if (len2 != 0) store_bytes(pa2, len2, wdata >> (8 * len1));
    end else begin
      r.read_data = load_bytes(pa1, len1);
      if (len2 != 0) r.read_data |= load_bytes(pa2, len2) << (8 * len1);
    end
    return r;
  endfunction

  task automatic send_item(op_e op, logic [31:0] addr, logic [2:0] len, logic [31:0] wdata);
    mem_result_t r;
    if (!steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, wdata, len, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = access_memory(op, addr, len, wdata);
    faults_seen += r.page_fault;
    ranges_seen += r.out_of_range;
    pending_results.push_back(r);
    items_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [19:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_PAGING) paging_on = value[0];
    else pd_frame = value;
    @(posedge clk_i);
  endtask

  // data lives in the first and last 16 bytes of frames 4 to 15
  function automatic logic [11:0] window_offset();
    return ($urandom_range(1) == 0) ? 12'($urandom_range(0, 12))
                                    : 12'($urandom_range(12'hff0, 12'hfff));
  endfunction

  function automatic logic [31:0] data_addr();
    return {16'd0, 4'($urandom_range(4, 15)), window_offset()};
  endfunction

  task automatic fill_memory();
    steady = 1'b1;
    for (int unsigned f = 4; f < 16; f++) begin
      for (int unsigned w = 0; w < 4; w++) begin
        send_item(OP_PHYS_WR, 32'h1000 * f + 4 * w, 3'd4, $urandom());
        send_item(OP_PHYS_WR, 32'h1000 * f + 32'hff0 + 4 * w, 3'd4, $urandom());
      end
    end
    steady = 1'b0;
  endtask

  // directory at frame 1, tables at frames 2 and 3, data in frames 4 to 15
  task automatic build_tables();
    logic [31:0] pte;
    send_item(OP_PHYS_WR, 32'h0, 3'd4, 32'h0000_0000);
    send_item(OP_PHYS_WR, PdAddr + 0, 3'd4, 32'h0000_2001);
    send_item(OP_PHYS_WR, PdAddr + 4, 3'd4, 32'h0000_3021);
    send_item(OP_PHYS_WR, PdAddr + 8, 3'd4, 32'h0000_2000);
    send_item(OP_PHYS_WR, PdAddr + 12, 3'd4, 32'h0020_0001);
    send_item(OP_PHYS_WR, PdAddr + 32'hffc, 3'd4, 32'h0000_2001);
    send_item(OP_PHYS_WR, 32'h2ffc, 3'd4, 32'h0000_f001);
    for (int unsigned t = 0; t < 2; t++) begin
      for (int unsigned i = 0; i < 16; i++) begin
        pte = {20'(4 + (i + t) % 12), 12'h001};
        if (i == 13) pte = 32'h0000_5000;
        if (i == 14) pte = 32'hffff_f061;
        if (i == 3) pte |= 32'h60;
        send_item(OP_PHYS_WR, 32'h2000 + 32'h1000 * t + 4 * i, 3'd4, pte);
      end
    end
  endtask

  function automatic logic [31:0] mapped_va();
    logic [31:0] va;
    va[31:22] = 10'($urandom_range(0, 3));
    va[21:12] = 10'($urandom_range(0, 14));
    va[11:0]  = window_offset();
    return va;
  endfunction

  task automatic test_physical();
    send_item(OP_PHYS_RD, 32'h0, 3'd1, '0);
    send_item(OP_PHYS_WR, 32'h4000, 3'd4, 32'hffff_ffff);
    send_item(OP_PHYS_RD, 32'h4000, 3'd4, '0);
    send_item(OP_PHYS_WR, 32'h4001, 3'd2, 32'h0000_0000);
    send_item(OP_PHYS_RD, 32'h4000, 3'd3, '0);
    send_item(OP_PHYS_RD, 32'h4000, 3'd0, '0);
    send_item(OP_PHYS_WR, 32'h4004, 3'd7, 32'ha5c3_3c5a);
    send_item(OP_PHYS_RD, 32'h4004, 3'd5, '0);
    send_item(OP_PHYS_RD, MemBytes - 4, 3'd4, '0);
    send_item(OP_PHYS_RD, MemBytes - 2, 3'd4, '0);
    send_item(OP_PHYS_WR, 32'hffff_ffff, 3'd2, 32'h1234_5678);
    send_item(OP_VIRT_RD, 32'h4004, 3'd4, '0);
    stop_sending();
  endtask

  task automatic test_virtual();
    write_reg(CFG_PDBASE, 20'd1);
    write_reg(CFG_PAGING, 1'b1);
    send_item(OP_VIRT_RD, 32'h0000_0008, 3'd4, '0);
    send_item(OP_VIRT_WR, 32'h0000_1ffe, 3'd4, 32'hdead_beef);
    send_item(OP_VIRT_RD, 32'h0000_1ffd, 3'd4, '0);
    send_item(OP_VIRT_WR, 32'h0040_3000, 3'd1, 32'h0000_0077);
    send_item(OP_VIRT_RD, 32'h0000_d004, 3'd2, '0);
    send_item(OP_VIRT_RD, 32'h0080_0000, 3'd4, '0);
    send_item(OP_VIRT_RD, 32'h00c0_0000, 3'd4, '0);
    send_item(OP_VIRT_WR, 32'h0000_e000, 3'd4, 32'h0);
    send_item(OP_VIRT_WR, 32'h0000_cffe, 3'd4, 32'h5555_aaaa);
    send_item(OP_VIRT_RD, 32'hffff_fffe, 3'd3, '0);
    send_item(OP_PHYS_RD, 32'h2000, 3'd4, '0);
    stop_sending();
    write_reg(CFG_PDBASE, 20'hfffff);
    send_item(OP_VIRT_RD, 32'h0000_0000, 3'd4, '0);
    send_item(OP_PHYS_RD, 32'h0000_4008, 3'd4, '0);
    stop_sending();
    write_reg(CFG_PDBASE, 20'd0);
    send_item(OP_VIRT_RD, 32'h0000_0000, 3'd4, '0);
    stop_sending();
  endtask

  task automatic test_random(int unsigned count);
    op_e op;
    logic [31:0] addr;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0 && n != 0) begin
        stop_sending();
        write_reg(CFG_PAGING, ($urandom_range(3) != 0));
      end
      steady = (n >= 200 && n < 260);
      pick = $urandom_range(99);
      op = op_e'($urandom_range(3));
      if (pick < 60) begin
        op = op_e'({1'b1, op[0]});
        addr = paging_on ? mapped_va() : data_addr();
      end else if (pick < 90) begin
        op = op_e'({1'b0, op[0]});
        addr = data_addr();
      end else begin
        op = op_e'({1'b0, op[0]});
        addr = {16'($urandom_range(1, 16'hffff)), 16'($urandom())};
      end
      send_item(op, addr, ($urandom_range(9) == 0) ? 3'($urandom()) : 3'($urandom_range(1, 4)),
                $urandom());
    end
    steady = 1'b0;
    stop_sending();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int unsigned n = 0; n < 40; n++) send_item(OP_VIRT_RD, mapped_va(), 3'd4, '0);
    stop_sending();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_memory();
    build_tables();
    stop_sending();
    test_physical();
    test_virtual();
    write_reg(CFG_PDBASE, 20'd1);
    write_reg(CFG_PAGING, 1'b1);
    test_random(330);
    write_reg(CFG_PAGING, 1'b1);
    test_backpressure();
    drain();
    $display("Covered %0d items and %0d results, %0d page faults, %0d out-of-range accesses,",
             items_sent, results_seen, faults_seen, ranges_seen);
    $display("with paging on and off and directory bases at both extremes.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
